### design/rdcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcs_pkg
// Types, codes and tables shared by the relay dedup and channel scan block.
// ----------------------------------------------------------------------------
package rdcs_pkg;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_CHANNEL_MODE  = 3'd0;
  localparam logic [2:0] CFG_MAX_HOPS      = 3'd1;
  localparam logic [2:0] CFG_MAX_FRAME_LEN = 3'd2;
  localparam logic [2:0] CFG_SCAN_DWELL_MS = 3'd3;
  localparam logic [2:0] CFG_RELOCK_MS     = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [2:0] {
    STAT_PASS      = 3'd0,
    STAT_INVALID   = 3'd1,
    STAT_CENSUS    = 3'd2,
    STAT_DUPLICATE = 3'd3,
    STAT_LIMIT     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic        frame_ok;
    logic        is_census;
    logic [7:0]  src_node;
    logic [7:0]  sequence_req;
    logic [7:0]  hops_done;
    logic [7:0]  frame_len;
  } item_t;

  typedef struct packed {
    logic       relay;
    logic [7:0] relay_hops;
    logic [2:0] frame_status;
    logic       retune;
    logic [3:0] active_channel;
    logic       locked;
  } result_t;

  // scan order over channels 1, 6, 11
  function automatic logic [3:0] scan_channel(input logic [1:0] idx);
    logic [3:0] ch;
    case (idx)
      2'd1:    ch = 4'd6;
      2'd2:    ch = 4'd11;
      default: ch = 4'd1;
    endcase
    return ch;
  endfunction

endpackage

### design/rdcs_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcs_item_if
// Valid/ready channel carrying one input item (frame or tick).
// ----------------------------------------------------------------------------
interface rdcs_item_if
  import rdcs_pkg::*;
;
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/rdcs_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcs_result_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface rdcs_result_if
  import rdcs_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/relay_dedup_and_channel_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_dedup_and_channel_scan_core
// Relay decision with duplicate suppression, plus auto channel scanning.
// ----------------------------------------------------------------------------
// Usage: item_i takes frames (command 0) and millisecond ticks (command 1);
// every transfer on item_i yields exactly one transfer on result_o. The
// configuration port is written while the block is idle.
// A valid non-census frame with a nonzero sequence walks the recent-pair ring
// one entry per cycle through a single key comparator on the ring memory's
// registered read port, and the walk ends early when a duplicate is found.
// Ticks and all other frames skip the walk. A new item is accepted only once
// the block is back in idle. When the walk ends, the finish state loads the
// result into the output register as soon as the output slot is free.
// The output register frees the sink side: the next item is accepted while a
// result still waits. If the receiver stalls with a result still held, the
// block holds the next result (and its state update) until the slot frees.
// Reset clears the ring's valid bits, the scan state and the lock, and loads
// the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module relay_dedup_and_channel_scan_core
  import rdcs_pkg::*;
#(
  parameter int unsigned DEDUP_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rdcs_item_if.sink             item_i,
  rdcs_result_if.source         result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (DEDUP_DEPTH > 1) ? $clog2(DEDUP_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEDUP_DEPTH - 1);

  // configuration
  logic [3:0]  mode_q;
  logic [7:0]  max_hops_q;
  logic [7:0]  max_len_q;
  logic [15:0] dwell_q;
  logic [19:0] relock_q;

  // sequencer and item
  state_e state_q, state_d;
  item_t  item_q;
  logic   dup_q, dup_d;

  // ring walk
  logic [15:0]            ring_mem [DEDUP_DEPTH];
  logic [DEDUP_DEPTH-1:0] ring_vld_q;
  logic [IDX_W-1:0]       head_q, head_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   issued_q, issued_d;
  logic                   cmp_q, cmp_d;
  logic                   cmp_last_q, cmp_last_d;
  logic [15:0]            rd_key_q;
  logic                   rd_vld_q;
  logic                   rd_en;
  logic                   ring_we;
  logic [15:0]            key;
  logic                   hit;

  // scan state
  logic        lock_q, lock_d;
  logic [1:0]  scan_q, scan_d;
  logic [31:0] probe_q, probe_d;
  logic [31:0] heard_q, heard_d;

  // output stage
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    slot_free;
  logic    fin_go;
  logic    accept;
  logic    tracked;

  // shared elapsed-time compare
  logic [31:0] since;
  logic [31:0] elapsed;
  logic [31:0] limit;
  logic        expired;

  assign key       = {item_q.src_node, item_q.sequence_req};
  assign hit       = cmp_q && rd_vld_q && (rd_key_q == key);
  assign slot_free = !out_valid_q || result_o.ready;
  assign fin_go    = (state_q == ST_FIN) && slot_free;
  assign accept    = item_i.valid && item_i.ready;
  assign tracked   = (item_i.payload.command == CMD_FRAME) && item_i.payload.frame_ok &&
                     !item_i.payload.is_census && (item_i.payload.sequence_req != 8'd0);

  assign since   = lock_q ? heard_q : probe_q;
  assign limit   = lock_q ? {12'd0, relock_q} : {16'd0, dwell_q};
  assign elapsed = item_q.now_ms - since;
  assign expired = elapsed >= limit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          state_d = tracked ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (hit || (cmp_q && cmp_last_q)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_i.ready = (state_q == ST_IDLE);

    idx_d      = idx_q;
    issued_d   = issued_q;
    cmp_d      = 1'b0;
    cmp_last_d = 1'b0;
    rd_en      = 1'b0;
    dup_d      = dup_q;
    ring_we    = 1'b0;
    head_d     = head_q;
    lock_d     = lock_q;
    scan_d     = scan_q;
    probe_d    = probe_q;
    heard_d    = heard_q;
    out_d      = out_q;

    if (accept) begin
      idx_d    = '0;
      issued_d = 1'b0;
      dup_d    = 1'b0;
    end

    if (state_q == ST_SCAN) begin
      if (!issued_q) begin
        rd_en      = 1'b1;
        cmp_d      = 1'b1;
        cmp_last_d = (idx_q == LAST_IDX);
        if (idx_q == LAST_IDX) begin
          issued_d = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      if (hit) begin
        dup_d = 1'b1;
      end
    end

    if (fin_go) begin
      out_d.relay        = 1'b0;
      out_d.relay_hops   = 8'd0;
      out_d.frame_status = STAT_PASS;
      out_d.retune       = 1'b0;
      if (item_q.command == CMD_FRAME) begin
        if (!item_q.frame_ok) begin
          out_d.frame_status = STAT_INVALID;
        end else if (item_q.is_census) begin
          out_d.frame_status = STAT_CENSUS;
        end else begin
          heard_d = item_q.now_ms;
          lock_d  = 1'b1;
          if (dup_q) begin
            out_d.frame_status = STAT_DUPLICATE;
          end else begin
            if (item_q.sequence_req != 8'd0) begin
              ring_we = 1'b1;
              head_d  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
            end
            if ((item_q.hops_done < max_hops_q) && (item_q.frame_len <= max_len_q)) begin
              out_d.relay      = 1'b1;
              out_d.relay_hops = item_q.hops_done + 8'd1;
            end else begin
              out_d.frame_status = STAT_LIMIT;
            end
          end
        end
      end else if ((mode_q == 4'd0) && expired) begin
        // drop the lock on silence, step to the next channel
        lock_d       = 1'b0;
        scan_d       = (scan_q >= 2'd2) ? 2'd0 : scan_q + 2'd1;
        probe_d      = item_q.now_ms;
        out_d.retune = 1'b1;
      end
      out_d.active_channel = (mode_q != 4'd0) ? mode_q : scan_channel(scan_d);
      out_d.locked         = (mode_q != 4'd0) || lock_d;
    end

    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    result_o.valid   = out_valid_q;
    result_o.payload = out_q;
  end

  // ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_q] <= key;
    end
    if (rd_en) begin
      rd_key_q <= ring_mem[idx_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i.payload;
    end
    if (fin_go) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dup_q       <= 1'b0;
      ring_vld_q  <= '0;
      head_q      <= '0;
      idx_q       <= '0;
      issued_q    <= 1'b0;
      cmp_q       <= 1'b0;
      cmp_last_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      lock_q      <= 1'b0;
      scan_q      <= 2'd0;
      probe_q     <= 32'd0;
      heard_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dup_q       <= dup_d;
      head_q      <= head_d;
      idx_q       <= idx_d;
      issued_q    <= issued_d;
      cmp_q       <= cmp_d;
      cmp_last_q  <= cmp_last_d;
      lock_q      <= lock_d;
      scan_q      <= scan_d;
      probe_q     <= probe_d;
      heard_q     <= heard_d;
      out_valid_q <= out_valid_d;
      if (rd_en) begin
        rd_vld_q <= ring_vld_q[idx_q];
      end
      if (ring_we) begin
        ring_vld_q[head_q] <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 4'd0;
      max_hops_q <= 8'd3;
      max_len_q  <= 8'd250;
      dwell_q    <= 16'd2000;
      relock_q   <= 20'd10000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANNEL_MODE:  mode_q     <= cfg_data_i[3:0];
        CFG_MAX_HOPS:      max_hops_q <= cfg_data_i[7:0];
        CFG_MAX_FRAME_LEN: max_len_q  <= cfg_data_i[7:0];
        CFG_SCAN_DWELL_MS: dwell_q    <= cfg_data_i[15:0];
        CFG_RELOCK_MS:     relock_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cmp_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_q |-> $past(state_q == ST_SCAN))
    else $error("ring compare pending outside the ring walk");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == ST_FIN))
    else $error("result loaded outside the finish step");

  a_lock_drop_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(lock_q) |-> $past(item_q.command == CMD_TICK))
    else $error("lock dropped by a frame");

  a_head_on_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != $past(head_q)) |-> $past(fin_go && (item_q.command == CMD_FRAME)))
    else $error("ring head moved outside a frame commit");
`endif

endmodule

### tb/relay_dedup_and_channel_scan_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_dedup_and_channel_scan_core_tb
// Self-checking bench for the relay decision and channel scan block. Frames
// and ticks are queued per configuration phase and sent with random gaps.
// Each accepted item runs through a local relay/scan predictor. Every result
// is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module relay_dedup_and_channel_scan_core_tb;
  import rdcs_pkg::*;

  localparam int unsigned DEDUP_DEPTH   = 16;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned PRESSURE_AT   = 400;
  localparam int unsigned PRESSURE_HOLD = 500;
  localparam logic [3:0]  SCAN_CHANNELS [3] = '{4'd1, 4'd6, 4'd11};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rdcs_item_if   item_bus ();
  rdcs_result_if result_bus ();

  relay_dedup_and_channel_scan_core #(
    .DEDUP_DEPTH(DEDUP_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_bus),
    .result_o   (result_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // predictor copy of the configuration
  logic [3:0]  mode_cfg   = 4'd0;
  logic [7:0]  hops_cfg   = 8'd3;
  logic [7:0]  len_cfg    = 8'd250;
  logic [15:0] dwell_cfg  = 16'd2000;
  logic [19:0] relock_cfg = 20'd10000;

  // predictor copy of the block state
  logic [15:0] seen_keys [DEDUP_DEPTH];
  int unsigned seen_head = 0;
  logic        lock_q    = 1'b0;
  logic [1:0]  scan_pos  = 2'd0;
  logic [31:0] probe_ms  = 32'd0;
  logic [31:0] heard_ms  = 32'd0;

  item_t       pending_items [$];
  result_t     expected_results [$];
  logic [31:0] clock_ms = 32'd0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    foreach (seen_keys[i]) seen_keys[i] = 16'd0;
  end

  function automatic result_t relay_predict(input item_t it);
    result_t     r;
    logic [15:0] key;
    logic [31:0] elapsed;
    logic        hit;
    r = '0;
    key = {it.src_node, it.sequence_req};
    hit = 1'b0;
    if (it.command == CMD_FRAME) begin
      if (!it.frame_ok) begin
        r.frame_status = STAT_INVALID;
      end else if (it.is_census) begin
        r.frame_status = STAT_CENSUS;
      end else begin
        heard_ms = it.now_ms;
        lock_q = 1'b1;
        if (it.sequence_req != 8'd0) begin
          foreach (seen_keys[i]) if (seen_keys[i] == key) hit = 1'b1;
        end
        if (hit) begin
          r.frame_status = STAT_DUPLICATE;
        end else begin
          // record even when the limits block the relay
          if (it.sequence_req != 8'd0) begin
            seen_keys[seen_head] = key;
            seen_head = (seen_head + 1) % DEDUP_DEPTH;
          end
          if (it.hops_done < hops_cfg && it.frame_len <= len_cfg) begin
            r.relay = 1'b1;
            r.relay_hops = it.hops_done + 8'd1;
          end else begin
            r.frame_status = STAT_LIMIT;
          end
        end
      end
    end else if (mode_cfg == 4'd0) begin
      elapsed = lock_q ? it.now_ms - heard_ms : it.now_ms - probe_ms;
      if ((!lock_q && elapsed >= {16'd0, dwell_cfg}) ||
          (lock_q && elapsed >= {12'd0, relock_cfg})) begin
        lock_q = 1'b0;
        scan_pos = (scan_pos == 2'd2) ? 2'd0 : scan_pos + 2'd1;
        probe_ms = it.now_ms;
        r.retune = 1'b1;
      end
    end
    r.active_channel = (mode_cfg != 4'd0) ? mode_cfg : SCAN_CHANNELS[scan_pos];
    r.locked = (mode_cfg != 4'd0) ? 1'b1 : lock_q;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [31:0] time_step();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return $urandom_range(0, 20);
    if (pick < 70) return $urandom_range(0, 2 * dwell_cfg + 2);
    if (pick < 80) return 32'(dwell_cfg);
    if (pick < 88) return $urandom_range(0, 2 * relock_cfg + 2);
    if (pick < 93) return 32'(relock_cfg);
    if (pick < 98) return $urandom_range(0, 3000);
    return $urandom_range(0, 32'h00FF_FFFF);
  endfunction

  function automatic item_t tick_item(input logic [31:0] now);
    item_t it;
    // frame fields carry junk on a tick
    it.command      = CMD_TICK;
    it.now_ms       = now;
    it.frame_ok     = 1'($urandom);
    it.is_census    = 1'($urandom);
    it.src_node     = 8'($urandom);
    it.sequence_req = 8'($urandom);
    it.hops_done    = 8'($urandom);
    it.frame_len    = 8'($urandom);
    return it;
  endfunction

  function automatic item_t frame_item(input logic [31:0] now, input logic ok,
                                       input logic census, input logic [7:0] src,
                                       input logic [7:0] seq, input logic [7:0] hop,
                                       input logic [7:0] len);
    item_t it;
    it.command      = CMD_FRAME;
    it.now_ms       = now;
    it.frame_ok     = ok;
    it.is_census    = census;
    it.src_node     = src;
    it.sequence_req = seq;
    it.hops_done    = hop;
    it.frame_len    = len;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    logic [31:0] now;
    pick = $urandom_range(0, 99);
    clock_ms = clock_ms + time_step();
    now = ($urandom_range(0, 49) == 0) ? $urandom : clock_ms;
    if (pick < 40) begin
      it = tick_item(now);
    end else if (pick < 52) begin
      // broken frame or census heartbeat, other fields random
      it = tick_item(now);
      it.command = CMD_FRAME;
      if (pick < 46) it.frame_ok = 1'b0;
      else it = frame_item(now, 1'b1, 1'b1, it.src_node, it.sequence_req,
                           it.hops_done, it.frame_len);
    end else begin
      // small key pool so the ring sees repeats and evictions
      it = frame_item(now, 1'b1, 1'b0,
                      ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                      ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 12)) : 8'($urandom),
                      ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6)) : 8'($urandom),
                      ($urandom_range(0, 1) == 0) ? len_cfg - 8'd1 + 8'($urandom_range(0, 2))
                                                  : 8'($urandom));
      if ($urandom_range(0, 9) < 3) it.hops_done = hops_cfg - 8'd1 + 8'($urandom_range(0, 2));
    end
    return it;
  endfunction

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_items.push_back(random_item());
  endtask

  // wait on the falling edge so queue and valid reads settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || item_bus.valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_CHANNEL_MODE:  mode_cfg   = value[3:0];
      CFG_MAX_HOPS:      hops_cfg   = value[7:0];
      CFG_MAX_FRAME_LEN: len_cfg    = value[7:0];
      CFG_SCAN_DWELL_MS: dwell_cfg  = value[15:0];
      CFG_RELOCK_MS:     relock_cfg = value[19:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------- driver
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  logic        send_stalled;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_bus.valid   <= 1'b0;
      item_bus.payload <= '0;
    end else begin
      send_stalled = item_bus.valid && !item_bus.ready;
      if (item_bus.valid && item_bus.ready) begin
        expected_results.push_back(relay_predict(item_bus.payload));
      end
      if (!send_stalled) begin
        if (send_gap > 0) begin
          item_bus.valid <= 1'b0;
          send_gap--;
        end else if (pending_items.size() > 0) begin
          item_bus.valid   <= 1'b1;
          item_bus.payload <= pending_items.pop_front();
          send_gap = (send_calm > 0) ? 0 : idle_gap();
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 399) == 0) send_calm = 200;
    end
  end

  // --------------------------------------------------------------- monitor
  int unsigned recv_hold = 0;
  int unsigned recv_calm = 0;
  int unsigned results_seen = 0;
  logic        pressure_done = 1'b0;
  result_t     want_res;
  result_t     got_res;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        results_seen++;
        got_res = result_bus.payload;
        if (expected_results.size() == 0) begin
          $error("result transfer with no prediction waiting");
          mismatch_count++;
        end else begin
          want_res = expected_results.pop_front();
          check_field("relay", want_res.relay, got_res.relay);
          check_field("relay_hops", want_res.relay_hops, got_res.relay_hops);
          check_field("frame_status", want_res.frame_status, got_res.frame_status);
          check_field("retune", want_res.retune, got_res.retune);
          check_field("active_channel", want_res.active_channel, got_res.active_channel);
          check_field("locked", want_res.locked, got_res.locked);
        end
      end
      if (recv_hold > 0) begin
        result_bus.ready <= 1'b0;
        recv_hold--;
      end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
        // long hold-off: the sender keeps offering and the block backs up
        pressure_done = 1'b1;
        recv_hold = PRESSURE_HOLD;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (recv_calm == 0 && $urandom_range(0, 3) == 0) recv_hold = idle_gap();
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 399) == 0) recv_calm = 200;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // -------------------------------------------------------------- sequence
  initial begin
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset configuration, scan, lock, ring and time wrap
    pending_items.push_back(tick_item(32'd0));
    pending_items.push_back(tick_item(32'd1999));
    pending_items.push_back(tick_item(32'd2000));
    pending_items.push_back(frame_item(32'd2100, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pending_items.push_back(frame_item(32'd2200, 1'b1, 1'b1, 8'h01, 8'h01, 8'h00, 8'h00));
    pending_items.push_back(frame_item(32'd2300, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(frame_item(32'd2300, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(frame_item(32'd2400, 1'b1, 1'b0, 8'h12, 8'h05, 8'h02, 8'd250));
    pending_items.push_back(frame_item(32'd2400, 1'b1, 1'b0, 8'h12, 8'h05, 8'h02, 8'd250));
    pending_items.push_back(frame_item(32'd2500, 1'b1, 1'b0, 8'h12, 8'h06, 8'h03, 8'd10));
    pending_items.push_back(frame_item(32'd2600, 1'b1, 1'b0, 8'h12, 8'h06, 8'h00, 8'd10));
    pending_items.push_back(frame_item(32'd2700, 1'b1, 1'b0, 8'h34, 8'h01, 8'h00, 8'd251));
    pending_items.push_back(frame_item(32'd2800, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pending_items.push_back(frame_item(32'd2900, 1'b1, 1'b0, 8'h00, 8'h01, 8'h00, 8'h00));
    pending_items.push_back(tick_item(32'd12899));
    pending_items.push_back(tick_item(32'd12900));
    pending_items.push_back(tick_item(32'd14899));
    pending_items.push_back(tick_item(32'd14900));
    pending_items.push_back(tick_item(32'hFFFF_FFFF));
    pending_items.push_back(tick_item(32'h0000_07CE));
    pending_items.push_back(tick_item(32'h0000_07CF));
    pending_items.push_back(frame_item(32'h0000_0800, 1'b1, 1'b0, 8'h12, 8'h05, 8'h00, 8'd1));
    clock_ms = 32'h0000_1000;
    queue_random(230);
    drain();

    // widest limits, zero timers
    write_reg(CFG_MAX_HOPS, 20'd255);
    write_reg(CFG_MAX_FRAME_LEN, 20'd255);
    write_reg(CFG_SCAN_DWELL_MS, 20'd0);
    write_reg(CFG_RELOCK_MS, 20'd0);
    queue_random(250);
    drain();

    // no relay possible, longest timers, time near wrap
    write_reg(CFG_MAX_HOPS, 20'd0);
    write_reg(CFG_MAX_FRAME_LEN, 20'd0);
    write_reg(CFG_SCAN_DWELL_MS, 20'hFFFF);
    write_reg(CFG_RELOCK_MS, 20'hFFFFF);
    clock_ms = 32'hFFFF_0000;
    queue_random(250);
    drain();

    // fixed channel
    write_reg(CFG_CHANNEL_MODE, 20'd6);
    write_reg(CFG_MAX_HOPS, 20'd4);
    write_reg(CFG_MAX_FRAME_LEN, 20'd128);
    write_reg(CFG_SCAN_DWELL_MS, 20'd100);
    write_reg(CFG_RELOCK_MS, 20'd500);
    queue_random(250);
    drain();

    // nonstandard and remaining fixed values
    write_reg(CFG_CHANNEL_MODE, 20'd15);
    queue_random(100);
    drain();
    write_reg(CFG_CHANNEL_MODE, 20'd11);
    queue_random(80);
    drain();
    write_reg(CFG_CHANNEL_MODE, 20'd1);
    queue_random(80);
    drain();

    // back to auto scan with short timers
    write_reg(CFG_CHANNEL_MODE, 20'd0);
    write_reg(CFG_MAX_HOPS, 20'd3);
    write_reg(CFG_MAX_FRAME_LEN, 20'd250);
    write_reg(CFG_SCAN_DWELL_MS, 20'd30);
    write_reg(CFG_RELOCK_MS, 20'd150);
    queue_random(300);
    drain();

    write_reg(CFG_SCAN_DWELL_MS, 20'd1);
    write_reg(CFG_RELOCK_MS, 20'd5);
    queue_random(190);
    drain();

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
